// ===== src/owbm_pkg.sv =====
// Shared types, codes and constants for the single-wire bus master.
// No dependencies; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package owbm_pkg;

   localparam int TIMER_BITS  = 10;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 10;

   typedef logic [TIMER_BITS-1:0] timer_type;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RESET_LOW     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PRESENCE_WAIT = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RESET_TAIL    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SLOT_START    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WRITE_HOLD    = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_READ_SAMPLE   = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_READ_TAIL     = 3'd6;

   // Request opcodes as they arrive on the port
   localparam logic [2:0] OP_TICK  = 3'd0;
   localparam logic [2:0] OP_RESET = 3'd1;
   localparam logic [2:0] OP_WRITE = 3'd2;
   localparam logic [2:0] OP_READ  = 3'd3;
   localparam logic [2:0] OP_TEMP  = 3'd4;

   // Bus commands
   localparam logic [7:0] ROM_SKIP        = 8'hCC;
   localparam logic [7:0] SCRATCHPAD_READ = 8'hBE;

   // Temperature sequence steps
   localparam logic [2:0] SEQ_NONE    = 3'd0;
   localparam logic [2:0] SEQ_SKIP    = 3'd1;
   localparam logic [2:0] SEQ_SCRATCH = 3'd2;
   localparam logic [2:0] SEQ_LOW     = 3'd3;
   localparam logic [2:0] SEQ_HIGH    = 3'd4;

   typedef enum logic [2:0] {
      CMD_TICK  = 3'd0,
      CMD_RESET = 3'd1,
      CMD_WRITE = 3'd2,
      CMD_READ  = 3'd3,
      CMD_TEMP  = 3'd4
   } cmd_type;

   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_RST_LOW  = 4'd1,
      PH_RST_WAIT = 4'd2,
      PH_RST_TAIL = 4'd3,
      PH_SLOT     = 4'd4,
      PH_WHOLD    = 4'd5,
      PH_RWAIT    = 4'd6,
      PH_RTAIL    = 4'd7
   } phase_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] data;
      logic       line;
   } item_type;

   typedef struct packed {
      logic [9:0] reset_low;
      logic [9:0] presence_wait;
      logic [9:0] reset_tail;
      logic [5:0] slot_start;
      logic [7:0] write_hold;
      logic [7:0] read_sample;
      logic [7:0] read_tail;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      reset_low:     10'd500,
      presence_wait: 10'd70,
      reset_tail:    10'd500,
      slot_start:    6'd2,
      write_hold:    8'd60,
      read_sample:   8'd15,
      read_tail:     8'd45
   };

endpackage

`default_nettype wire

// ===== src/owbm_front.sv =====
// Front end: takes requests and classifies the opcode into a bus command.
// Depends on owbm_pkg; feeds owbm_queue.
`timescale 1ns / 1ps
`default_nettype none

module owbm_front (
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [2:0]           req_opcode,
   input  wire logic [7:0]           req_data_byte,
   input  wire logic                 req_line_level,
   input  wire logic                 push_ready,
   output logic                      push_valid,
   output owbm_pkg::item_type        push_item
);

   owbm_pkg::cmd_type cmd;

   // Unknown opcodes behave as plain ticks
   always_comb begin
      case (req_opcode)
         owbm_pkg::OP_RESET: cmd = owbm_pkg::CMD_RESET;
         owbm_pkg::OP_WRITE: cmd = owbm_pkg::CMD_WRITE;
         owbm_pkg::OP_READ:  cmd = owbm_pkg::CMD_READ;
         owbm_pkg::OP_TEMP:  cmd = owbm_pkg::CMD_TEMP;
         default:            cmd = owbm_pkg::CMD_TICK;
      endcase
   end

   assign push_valid     = req_valid;
   assign req_ready      = push_ready;
   assign push_item.cmd  = cmd;
   assign push_item.data = (cmd == owbm_pkg::CMD_WRITE) ? req_data_byte : 8'h00;
   assign push_item.line = req_line_level;

endmodule

`default_nettype wire

// ===== src/owbm_queue.sv =====
// Short request queue between the front end and the bus engine.
// Depends on owbm_pkg for the item type and depth.
`timescale 1ns / 1ps
`default_nettype none

module owbm_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire owbm_pkg::item_type   in_item,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output owbm_pkg::item_type        out_item
);

   owbm_pkg::item_type                  entries_ff [owbm_pkg::QUEUE_DEPTH];
   logic [owbm_pkg::QPTR_BITS-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [owbm_pkg::QPTR_BITS-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [owbm_pkg::QCNT_BITS-1:0]      count_ff, count_in;
   logic                                push, pop;

   assign in_ready  = (count_ff != owbm_pkg::QCNT_BITS'(owbm_pkg::QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_item  = entries_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == owbm_pkg::QPTR_BITS'(owbm_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == owbm_pkg::QPTR_BITS'(owbm_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

`default_nettype wire

// ===== src/owbm_back.sv =====
// Bus engine: slot timing state machine, timing registers and result register.
// Depends on owbm_pkg; takes items from owbm_queue.
`timescale 1ns / 1ps
`default_nettype none

module owbm_back (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write_enable,
   input  wire logic [owbm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [owbm_pkg::CSR_DATA_BITS-1:0]  csr_write_data,
   input  wire logic                                item_valid,
   output logic                                     item_ready,
   input  wire owbm_pkg::item_type                  item,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_drive_low,
   output logic                                     rsp_busy_res,
   output logic                                     rsp_done_res,
   output logic                                     rsp_presence,
   output logic [7:0]                               rsp_read_data,
   output logic signed [15:0]                       rsp_temperature
);

   owbm_pkg::cfg_type   cfg_ff;
   owbm_pkg::phase_type phase_ff, phase_in;
   owbm_pkg::cmd_type   kind_ff, kind_in;
   owbm_pkg::timer_type timer_ff, timer_in;
   logic [2:0]          bit_ff, bit_in;
   logic [2:0]          seq_ff, seq_in;
   logic [7:0]          shift_ff, shift_in;
   logic [7:0]          low_ff, low_in;
   logic                presence_ff, presence_in;
   logic [7:0]          last_read_ff, last_read_in;
   logic [15:0]         temp_ff, temp_in;
   logic                done_ff, done_in;
   logic                rsp_valid_ff;
   logic                step;
   logic                timer_done;
   logic                end_of_bit;
   logic                start_byte;
   logic [7:0]          byte_value;
   logic                slot_is_write;
   logic                drive;

   assign step       = item_valid && (!rsp_valid_ff || rsp_ready);
   assign item_ready = !rsp_valid_ff || rsp_ready;
   assign timer_done = (timer_ff <= owbm_pkg::timer_type'(1));
   assign slot_is_write = (kind_ff == owbm_pkg::CMD_WRITE) ||
                          ((kind_ff == owbm_pkg::CMD_TEMP) &&
                           ((seq_ff == owbm_pkg::SEQ_SKIP) || (seq_ff == owbm_pkg::SEQ_SCRATCH)));

   // Timing registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= owbm_pkg::CFG_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            owbm_pkg::CSR_RESET_LOW:     cfg_ff.reset_low     <= csr_write_data;
            owbm_pkg::CSR_PRESENCE_WAIT: cfg_ff.presence_wait <= csr_write_data;
            owbm_pkg::CSR_RESET_TAIL:    cfg_ff.reset_tail    <= csr_write_data;
            owbm_pkg::CSR_SLOT_START:    cfg_ff.slot_start    <= csr_write_data[5:0];
            owbm_pkg::CSR_WRITE_HOLD:    cfg_ff.write_hold    <= csr_write_data[7:0];
            owbm_pkg::CSR_READ_SAMPLE:   cfg_ff.read_sample   <= csr_write_data[7:0];
            owbm_pkg::CSR_READ_TAIL:     cfg_ff.read_tail     <= csr_write_data[7:0];
            default: ;
         endcase
      end
   end

   // Next state
   always_comb begin
      phase_in     = phase_ff;
      kind_in      = kind_ff;
      timer_in     = timer_ff;
      bit_in       = bit_ff;
      seq_in       = seq_ff;
      shift_in     = shift_ff;
      low_in       = low_ff;
      presence_in  = presence_ff;
      last_read_in = last_read_ff;
      temp_in      = temp_ff;
      end_of_bit   = 1'b0;
      start_byte   = 1'b0;
      byte_value   = 8'h00;

      if (phase_ff != owbm_pkg::PH_IDLE) begin
         timer_in = timer_done ? '0 : timer_ff - 1'b1;
      end

      case (phase_ff)
         owbm_pkg::PH_IDLE: begin
            if (item.cmd != owbm_pkg::CMD_TICK) begin
               kind_in = item.cmd;
               seq_in  = owbm_pkg::SEQ_NONE;
               if (item.cmd == owbm_pkg::CMD_RESET || item.cmd == owbm_pkg::CMD_TEMP) begin
                  phase_in = owbm_pkg::PH_RST_LOW;
                  timer_in = owbm_pkg::timer_type'(cfg_ff.reset_low);
               end else begin
                  start_byte = 1'b1;
                  byte_value = item.data;
               end
            end
         end
         owbm_pkg::PH_RST_LOW: begin
            if (timer_done) begin
               phase_in = owbm_pkg::PH_RST_WAIT;
               timer_in = owbm_pkg::timer_type'(cfg_ff.presence_wait);
            end
         end
         owbm_pkg::PH_RST_WAIT: begin
            if (timer_done) begin
               presence_in = !item.line;
               phase_in    = owbm_pkg::PH_RST_TAIL;
               timer_in    = owbm_pkg::timer_type'(cfg_ff.reset_tail);
            end
         end
         owbm_pkg::PH_RST_TAIL: begin
            if (timer_done) begin
               if (kind_ff == owbm_pkg::CMD_TEMP) begin
                  seq_in     = owbm_pkg::SEQ_SKIP;
                  start_byte = 1'b1;
                  byte_value = owbm_pkg::ROM_SKIP;
               end else begin
                  phase_in = owbm_pkg::PH_IDLE;
               end
            end
         end
         owbm_pkg::PH_SLOT: begin
            if (timer_done) begin
               if (slot_is_write) begin
                  phase_in = owbm_pkg::PH_WHOLD;
                  timer_in = owbm_pkg::timer_type'(cfg_ff.write_hold);
               end else begin
                  phase_in = owbm_pkg::PH_RWAIT;
                  timer_in = owbm_pkg::timer_type'(cfg_ff.read_sample);
               end
            end
         end
         owbm_pkg::PH_RWAIT: begin
            if (timer_done) begin
               shift_in[bit_ff] = shift_ff[bit_ff] | item.line;
               phase_in = owbm_pkg::PH_RTAIL;
               timer_in = owbm_pkg::timer_type'(cfg_ff.read_tail);
            end
         end
         owbm_pkg::PH_WHOLD, owbm_pkg::PH_RTAIL: begin
            end_of_bit = timer_done;
         end
         default: begin
            phase_in = owbm_pkg::PH_IDLE;
         end
      endcase

      if (end_of_bit) begin
         if (bit_ff == 3'd7) begin
            // Byte complete: either finish or chain the next byte
            if (kind_ff == owbm_pkg::CMD_WRITE) begin
               phase_in = owbm_pkg::PH_IDLE;
            end else if (kind_ff == owbm_pkg::CMD_READ) begin
               last_read_in = shift_ff;
               phase_in     = owbm_pkg::PH_IDLE;
            end else if (seq_ff == owbm_pkg::SEQ_SKIP) begin
               seq_in     = owbm_pkg::SEQ_SCRATCH;
               start_byte = 1'b1;
               byte_value = owbm_pkg::SCRATCHPAD_READ;
            end else if (seq_ff == owbm_pkg::SEQ_SCRATCH) begin
               seq_in     = owbm_pkg::SEQ_LOW;
               start_byte = 1'b1;
            end else if (seq_ff == owbm_pkg::SEQ_LOW) begin
               low_in       = shift_ff;
               last_read_in = shift_ff;
               seq_in       = owbm_pkg::SEQ_HIGH;
               start_byte   = 1'b1;
            end else begin
               last_read_in = shift_ff;
               temp_in      = {shift_ff, low_ff};
               phase_in     = owbm_pkg::PH_IDLE;
            end
         end else begin
            bit_in   = bit_ff + 1'b1;
            phase_in = owbm_pkg::PH_SLOT;
            timer_in = owbm_pkg::timer_type'(cfg_ff.slot_start);
         end
      end

      if (start_byte) begin
         shift_in = byte_value;
         bit_in   = 3'd0;
         phase_in = owbm_pkg::PH_SLOT;
         timer_in = owbm_pkg::timer_type'(cfg_ff.slot_start);
      end
   end

   // Outputs
   always_comb begin
      done_in = (phase_ff != owbm_pkg::PH_IDLE) && (phase_in == owbm_pkg::PH_IDLE);
      case (phase_ff)
         owbm_pkg::PH_RST_LOW, owbm_pkg::PH_SLOT: drive = 1'b1;
         owbm_pkg::PH_WHOLD:                      drive = !shift_ff[bit_ff];
         default:                                 drive = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= owbm_pkg::PH_IDLE;
         kind_ff      <= owbm_pkg::CMD_TICK;
         timer_ff     <= '0;
         bit_ff       <= '0;
         seq_ff       <= owbm_pkg::SEQ_NONE;
         shift_ff     <= '0;
         low_ff       <= '0;
         presence_ff  <= 1'b0;
         last_read_ff <= '0;
         temp_ff      <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (step) begin
            phase_ff     <= phase_in;
            kind_ff      <= kind_in;
            timer_ff     <= timer_in;
            bit_ff       <= bit_in;
            seq_ff       <= seq_in;
            shift_ff     <= shift_in;
            low_ff       <= low_in;
            presence_ff  <= presence_in;
            last_read_ff <= last_read_in;
            temp_ff      <= temp_in;
            done_ff      <= done_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // State only moves on a taken item, so it holds the result while it waits
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_drive_low   = drive;
   assign rsp_busy_res    = (phase_ff != owbm_pkg::PH_IDLE);
   assign rsp_done_res    = done_ff;
   assign rsp_presence    = presence_ff;
   assign rsp_read_data   = last_read_ff;
   assign rsp_temperature = signed'(temp_ff);

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && done_ff) |-> (phase_ff == owbm_pkg::PH_IDLE))
      else $error("done flagged while a command is still running");

   a_idle_timer: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == owbm_pkg::PH_IDLE) |-> (timer_ff == '0))
      else $error("timer left running in idle");

   a_seq_temp: assert property (@(posedge clock) disable iff (reset)
      (seq_ff != owbm_pkg::SEQ_NONE) |-> (kind_ff == owbm_pkg::CMD_TEMP))
      else $error("sequence step set outside a temperature read");

   a_hold_state: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(phase_ff) && $stable(timer_ff))
      else $error("engine advanced without taking an item");

endmodule

`default_nettype wire

// ===== src/one_wire_bus_master.sv =====
// Single-wire bus master: one request per microsecond tick, one response per request.
// A request is registered in the queue, then the engine registers its response.
// Throughput: one request per cycle unless rsp_ready stalls the owbm_back engine.
// The two-entry queue lets front and engine stall independently.
// Reset: synchronous, active high; engine idle, timing registers at their defaults.
`timescale 1ns / 1ps
`default_nettype none

module one_wire_bus_master (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write_enable,
   input  wire logic [owbm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [owbm_pkg::CSR_DATA_BITS-1:0]  csr_write_data,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [2:0]                          req_opcode,
   input  wire logic [7:0]                          req_data_byte,
   input  wire logic                                req_line_level,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_drive_low,
   output logic                                     rsp_busy_res,
   output logic                                     rsp_done_res,
   output logic                                     rsp_presence,
   output logic [7:0]                               rsp_read_data,
   output logic signed [15:0]                       rsp_temperature
);

   logic               push_valid, push_ready;
   owbm_pkg::item_type push_item;
   logic               pop_valid, pop_ready;
   owbm_pkg::item_type pop_item;

   owbm_front u_front (
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_data_byte  (req_data_byte),
      .req_line_level (req_line_level),
      .push_ready     (push_ready),
      .push_valid     (push_valid),
      .push_item      (push_item)
   );

   owbm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_item   (push_item),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_item  (pop_item)
   );

   owbm_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .item_valid       (pop_valid),
      .item_ready       (pop_ready),
      .item             (pop_item),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_drive_low    (rsp_drive_low),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_done_res     (rsp_done_res),
      .rsp_presence     (rsp_presence),
      .rsp_read_data    (rsp_read_data),
      .rsp_temperature  (rsp_temperature)
   );

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking bench for one_wire_bus_master: drives tick and command requests,
// mimics a bus slave on the line level, and checks each response against a predictor.
// Depends on owbm_pkg and the one_wire_bus_master RTL only.
`timescale 1ns / 1ps

module testbench;

   localparam int          CYCLE_LIMIT          = 500_000;
   localparam int          RECEIVER_HOLD_CYCLES = 150;
   localparam logic [2:0]  OP_LAST_SPARE        = 3'd7;

   typedef struct packed {
      logic              drive_low;
      logic              busy;
      logic              done;
      logic              presence;
      logic [7:0]        read_data;
      logic [15:0]       temperature;
   } bus_status_type;

   logic                                clock;
   logic                                reset            = 1'b1;
   logic                                csr_write_enable = 1'b0;
   logic [owbm_pkg::CSR_INDEX_BITS-1:0] csr_index        = '0;
   logic [owbm_pkg::CSR_DATA_BITS-1:0]  csr_write_data   = '0;
   logic                                req_valid        = 1'b0;
   logic                                req_ready;
   logic [2:0]                          req_opcode       = owbm_pkg::OP_TICK;
   logic [7:0]                          req_data_byte    = '0;
   logic                                req_line_level   = 1'b1;
   logic                                rsp_valid;
   logic                                rsp_ready        = 1'b0;
   logic                                rsp_drive_low;
   logic                                rsp_busy_res;
   logic                                rsp_done_res;
   logic                                rsp_presence;
   logic [7:0]                          rsp_read_data;
   logic signed [15:0]                  rsp_temperature;

   one_wire_bus_master dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_data_byte    (req_data_byte),
      .req_line_level   (req_line_level),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_drive_low    (rsp_drive_low),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_done_res     (rsp_done_res),
      .rsp_presence     (rsp_presence),
      .rsp_read_data    (rsp_read_data),
      .rsp_temperature  (rsp_temperature)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   bus_status_type expected_status[$];
   int             mismatch_count     = 0;
   int             responses_checked  = 0;
   int             requests_sent      = 0;
   int             cycle_count        = 0;
   int             sender_idle_pct    = 0;
   int             receiver_stall_pct = 0;
   logic           receiver_hold      = 1'b0;

   // Predicted state of the bus master
   owbm_pkg::phase_type bus_phase;
   owbm_pkg::cmd_type   cmd_kind;
   owbm_pkg::timer_type slot_timer;
   logic [2:0]          bit_pos;
   logic [2:0]          temp_step;
   logic [7:0]          shift_reg;
   logic [7:0]          low_byte_held;
   logic [7:0]          last_byte;
   logic                presence_seen;
   logic [15:0]         last_temp;
   logic                cmd_done;
   owbm_pkg::cfg_type   timing;

   function automatic void clear_prediction();
      bus_phase     = owbm_pkg::PH_IDLE;
      cmd_kind      = owbm_pkg::CMD_TICK;
      slot_timer    = '0;
      bit_pos       = '0;
      temp_step     = owbm_pkg::SEQ_NONE;
      shift_reg     = '0;
      low_byte_held = '0;
      last_byte     = '0;
      presence_seen = 1'b0;
      last_temp     = '0;
      cmd_done      = 1'b0;
      timing        = owbm_pkg::CFG_RESET;
   endfunction

   function automatic void load_timer(input int unsigned value);
      slot_timer = owbm_pkg::timer_type'(value);
   endfunction

   function automatic logic timer_done();
      if (slot_timer > 1) begin
         slot_timer = slot_timer - 1'b1;
         return 1'b0;
      end
      slot_timer = '0;
      return 1'b1;
   endfunction

   function automatic void end_command();
      bus_phase = owbm_pkg::PH_IDLE;
      cmd_done  = 1'b1;
   endfunction

   function automatic void start_byte(input logic [7:0] value);
      shift_reg = value;
      bit_pos   = '0;
      bus_phase = owbm_pkg::PH_SLOT;
      load_timer(timing.slot_start);
   endfunction

   function automatic void complete_byte();
      if (cmd_kind == owbm_pkg::CMD_WRITE) begin
         end_command();
      end else if (cmd_kind == owbm_pkg::CMD_READ) begin
         last_byte = shift_reg;
         end_command();
      end else if (temp_step == owbm_pkg::SEQ_SKIP) begin
         temp_step = owbm_pkg::SEQ_SCRATCH;
         start_byte(owbm_pkg::SCRATCHPAD_READ);
      end else if (temp_step == owbm_pkg::SEQ_SCRATCH) begin
         temp_step = owbm_pkg::SEQ_LOW;
         start_byte(8'h00);
      end else if (temp_step == owbm_pkg::SEQ_LOW) begin
         low_byte_held = shift_reg;
         last_byte     = shift_reg;
         temp_step     = owbm_pkg::SEQ_HIGH;
         start_byte(8'h00);
      end else begin
         last_byte = shift_reg;
         last_temp = {shift_reg, low_byte_held};
         end_command();
      end
   endfunction

   function automatic void complete_bit();
      if (bit_pos == 3'd7) begin
         complete_byte();
      end else begin
         bit_pos   = bit_pos + 1'b1;
         bus_phase = owbm_pkg::PH_SLOT;
         load_timer(timing.slot_start);
      end
   endfunction

   function automatic void advance_phase(input logic line);
      case (bus_phase)
         owbm_pkg::PH_RST_LOW: if (timer_done()) begin
            bus_phase = owbm_pkg::PH_RST_WAIT;
            load_timer(timing.presence_wait);
         end
         owbm_pkg::PH_RST_WAIT: if (timer_done()) begin
            presence_seen = !line;
            bus_phase     = owbm_pkg::PH_RST_TAIL;
            load_timer(timing.reset_tail);
         end
         owbm_pkg::PH_RST_TAIL: if (timer_done()) begin
            if (cmd_kind == owbm_pkg::CMD_TEMP) begin
               temp_step = owbm_pkg::SEQ_SKIP;
               start_byte(owbm_pkg::ROM_SKIP);
            end else begin
               end_command();
            end
         end
         owbm_pkg::PH_SLOT: if (timer_done()) begin
            if (cmd_kind == owbm_pkg::CMD_WRITE || (cmd_kind == owbm_pkg::CMD_TEMP &&
                (temp_step == owbm_pkg::SEQ_SKIP || temp_step == owbm_pkg::SEQ_SCRATCH))) begin
               bus_phase = owbm_pkg::PH_WHOLD;
               load_timer(timing.write_hold);
            end else begin
               bus_phase = owbm_pkg::PH_RWAIT;
               load_timer(timing.read_sample);
            end
         end
         owbm_pkg::PH_WHOLD: if (timer_done()) complete_bit();
         owbm_pkg::PH_RWAIT: if (timer_done()) begin
            if (line) shift_reg[bit_pos] = 1'b1;
            bus_phase = owbm_pkg::PH_RTAIL;
            load_timer(timing.read_tail);
         end
         owbm_pkg::PH_RTAIL: if (timer_done()) complete_bit();
         default: bus_phase = owbm_pkg::PH_IDLE;
      endcase
   endfunction

   function automatic bus_status_type predict_status(input logic [2:0] op,
                                                     input logic [7:0] data,
                                                     input logic line);
      bus_status_type s;
      cmd_done = 1'b0;
      if (bus_phase == owbm_pkg::PH_IDLE) begin
         if (op >= owbm_pkg::OP_RESET && op <= owbm_pkg::OP_TEMP) begin
            cmd_kind  = owbm_pkg::cmd_type'(op);
            temp_step = owbm_pkg::SEQ_NONE;
            if (op == owbm_pkg::OP_RESET || op == owbm_pkg::OP_TEMP) begin
               bus_phase = owbm_pkg::PH_RST_LOW;
               load_timer(timing.reset_low);
            end else begin
               start_byte(op == owbm_pkg::OP_WRITE ? data : 8'h00);
            end
         end
      end else begin
         advance_phase(line);
      end
      s.drive_low   = bus_phase == owbm_pkg::PH_RST_LOW || bus_phase == owbm_pkg::PH_SLOT ||
                      (bus_phase == owbm_pkg::PH_WHOLD && !shift_reg[bit_pos]);
      s.busy        = bus_phase != owbm_pkg::PH_IDLE;
      s.done        = cmd_done;
      s.presence    = presence_seen;
      s.read_data   = last_byte;
      s.temperature = last_temp;
      return s;
   endfunction

   // Line level a slave would present: presence on the sample, reply bits in read slots
   function automatic logic slave_level(input logic [15:0] reply, input logic present);
      if (bus_phase == owbm_pkg::PH_RST_WAIT) return !present;
      if (bus_phase == owbm_pkg::PH_RWAIT) begin
         if (cmd_kind == owbm_pkg::CMD_TEMP && temp_step == owbm_pkg::SEQ_HIGH)
            return reply[8 + bit_pos];
         return reply[bit_pos];
      end
      return 1'($urandom);
   endfunction

   function automatic owbm_pkg::cfg_type make_timing(input int unsigned rst_low,
                                                     input int unsigned pres,
                                                     input int unsigned rst_tail,
                                                     input int unsigned slot,
                                                     input int unsigned hold,
                                                     input int unsigned sample,
                                                     input int unsigned tail);
      owbm_pkg::cfg_type c;
      c.reset_low     = 10'(rst_low);
      c.presence_wait = 10'(pres);
      c.reset_tail    = 10'(rst_tail);
      c.slot_start    = 6'(slot);
      c.write_hold    = 8'(hold);
      c.read_sample   = 8'(sample);
      c.read_tail     = 8'(tail);
      return c;
   endfunction

   task automatic flag_mismatch(input string what, input logic [15:0] got,
                                input logic [15:0] want);
      $display("mismatch: %s on response %0d: got %h, expected %h",
               what, responses_checked, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   // Response side: compare each accepted response, then choose the next ready
   always @(posedge clock) begin : response_check
      bus_status_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_status.size() == 0) begin
               flag_mismatch("unexpected response", '0, '0);
            end else begin
               want = expected_status.pop_front();
               if (rsp_drive_low !== want.drive_low)
                  flag_mismatch("drive_low", rsp_drive_low, want.drive_low);
               if (rsp_busy_res !== want.busy)
                  flag_mismatch("busy_res", rsp_busy_res, want.busy);
               if (rsp_done_res !== want.done)
                  flag_mismatch("done_res", rsp_done_res, want.done);
               if (rsp_presence !== want.presence)
                  flag_mismatch("presence", rsp_presence, want.presence);
               if (rsp_read_data !== want.read_data)
                  flag_mismatch("read_data", rsp_read_data, want.read_data);
               if (rsp_temperature !== want.temperature)
                  flag_mismatch("temperature", rsp_temperature, want.temperature);
            end
            responses_checked++;
         end
         if (receiver_hold) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
         end
      end
   end

   // Hold the receiver off for a fixed stretch, counted in its own process
   task automatic hold_receiver();
      fork
         begin : receiver_hold_count
            receiver_hold <= 1'b1;
            repeat (RECEIVER_HOLD_CYCLES) @(posedge clock);
            receiver_hold <= 1'b0;
         end
      join_none
   endtask

   // Leaves valid high after acceptance; the next call or a drain replaces or drops it
   task automatic send_request(input logic [2:0] op, input logic [7:0] data, input logic line);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_opcode     <= op;
      req_data_byte  <= data;
      req_line_level <= line;
      do @(posedge clock); while (!req_ready);
      expected_status.push_back(predict_status(op, data, line));
      requests_sent++;
   endtask

   task automatic wait_for_responses();
      req_valid <= 1'b0;
      while (expected_status.size() != 0) @(posedge clock);
   endtask

   task automatic put_register(input logic [owbm_pkg::CSR_INDEX_BITS-1:0] idx,
                               input logic [owbm_pkg::CSR_DATA_BITS-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
   endtask

   // Spare upper bits of the narrow registers carry noise, which the block must drop
   task automatic program_timing(input owbm_pkg::cfg_type c);
      wait_for_responses();
      put_register(owbm_pkg::CSR_RESET_LOW,     c.reset_low);
      put_register(owbm_pkg::CSR_PRESENCE_WAIT, c.presence_wait);
      put_register(owbm_pkg::CSR_RESET_TAIL,    c.reset_tail);
      put_register(owbm_pkg::CSR_SLOT_START,    {4'($urandom_range(0, 15)), c.slot_start});
      put_register(owbm_pkg::CSR_WRITE_HOLD,    {2'($urandom_range(0, 3)), c.write_hold});
      put_register(owbm_pkg::CSR_READ_SAMPLE,   {2'($urandom_range(0, 3)), c.read_sample});
      put_register(owbm_pkg::CSR_READ_TAIL,     {2'($urandom_range(0, 3)), c.read_tail});
      csr_write_enable <= 1'b0;
      timing = c;
   endtask

   // Shorten slot start and write hold only; the read registers keep their values
   task automatic shorten_write_slots();
      wait_for_responses();
      put_register(owbm_pkg::CSR_SLOT_START, 10'd1);
      put_register(owbm_pkg::CSR_WRITE_HOLD, 10'd1);
      csr_write_enable <= 1'b0;
      timing.slot_start = 6'd1;
      timing.write_hold = 8'd1;
   endtask

   // Tick until the command ends; now and then slip in a command that must be ignored
   task automatic finish_command(input logic [15:0] reply, input logic present);
      logic [2:0] op;
      while (bus_phase != owbm_pkg::PH_IDLE) begin
         op = ($urandom_range(0, 99) < 3) ?
              3'($urandom_range(owbm_pkg::OP_RESET, OP_LAST_SPARE)) : owbm_pkg::OP_TICK;
         send_request(op, 8'($urandom), slave_level(reply, present));
      end
   endtask

   // Tick through the first bit slot of the running byte
   task automatic tick_first_bit(input logic [15:0] reply, input logic present);
      while (bus_phase != owbm_pkg::PH_IDLE && bit_pos == 3'd0)
         send_request(owbm_pkg::OP_TICK, 8'($urandom), slave_level(reply, present));
   endtask

   task automatic run_command(input logic [2:0] op, input logic [7:0] data,
                              input logic [15:0] reply, input logic present);
      send_request(op, data, 1'($urandom));
      finish_command(reply, present);
   endtask

   // First slot of each byte on reset hold/sample/tail values, the rest on short slots
   task automatic test_default_timing();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      send_request(owbm_pkg::OP_WRITE, 8'hC2, 1'($urandom));
      tick_first_bit(16'h0000, 1'b1);
      shorten_write_slots();
      finish_command(16'h0000, 1'b1);
      send_request(owbm_pkg::OP_READ, 8'h00, 1'($urandom));
      tick_first_bit(16'h00A5, 1'b1);
      program_timing(make_timing(1, 1, 1, 1, 1, 1, 1));
      finish_command(16'h00A5, 1'b1);
   endtask

   task automatic test_opcodes_and_corners();
      logic [2:0] op;
      program_timing(make_timing(1, 1, 1, 1, 1, 1, 1));
      send_request(owbm_pkg::OP_TICK, 8'hFF, 1'b1);
      for (op = owbm_pkg::OP_TEMP + 1'b1; op != owbm_pkg::OP_TICK; op++)
         send_request(op, 8'h5A, 1'b0);
      run_command(owbm_pkg::OP_RESET, 8'h00, 16'h0000, 1'b1);
      run_command(owbm_pkg::OP_RESET, 8'hFF, 16'h0000, 1'b0);
      run_command(owbm_pkg::OP_WRITE, 8'h00, 16'h0000, 1'b1);
      run_command(owbm_pkg::OP_WRITE, 8'hFF, 16'h0000, 1'b1);
      run_command(owbm_pkg::OP_READ, 8'h00, 16'h005A, 1'b1);
      // commands arriving mid-write fall through as ticks
      send_request(owbm_pkg::OP_WRITE, 8'h3C, 1'b0);
      send_request(owbm_pkg::OP_READ, 8'h00, 1'b1);
      send_request(owbm_pkg::OP_TEMP, 8'h00, 1'b0);
      send_request(owbm_pkg::OP_RESET, 8'h00, 1'b1);
      send_request(OP_LAST_SPARE, 8'hFF, 1'b0);
      finish_command(16'h0000, 1'b1);
      // most negative reading, no slave answering the reset
      run_command(owbm_pkg::OP_TEMP, 8'h00, 16'h8000, 1'b0);
   endtask

   task automatic test_zero_timing();
      program_timing(make_timing(0, 0, 0, 0, 0, 0, 0));
      sender_idle_pct    = 46;
      receiver_stall_pct = 0;
      run_command(owbm_pkg::OP_RESET, 8'h00, 16'h0000, 1'b1);
      run_command(owbm_pkg::OP_WRITE, 8'hA5, 16'h0000, 1'b1);
      run_command(owbm_pkg::OP_READ, 8'h00, 16'h003C, 1'b1);
   endtask

   // Retime the bus mid-command: new values apply from the next timer load
   task automatic test_retime_mid_command();
      int i;
      program_timing(make_timing(4, 3, 6, 2, 3, 2, 2));
      sender_idle_pct    = 0;
      receiver_stall_pct = 46;
      send_request(owbm_pkg::OP_RESET, 8'h00, 1'b1);
      for (i = 0; i < 2; i++) send_request(owbm_pkg::OP_TICK, 8'($urandom), 1'b0);
      program_timing(make_timing(2, 5, 1, 1, 1, 1, 1));
      finish_command(16'h0000, 1'b1);
   endtask

   // Widest slot start on the first bit, then short slots
   task automatic test_max_timing();
      program_timing(make_timing(1, 1, 1, 63, 1, 1, 1));
      sender_idle_pct    = 35;
      receiver_stall_pct = 35;
      send_request(owbm_pkg::OP_WRITE, 8'h96, 1'($urandom));
      tick_first_bit(16'h0000, 1'b1);
      program_timing(make_timing(1, 1, 1, 1, 1, 1, 1));
      finish_command(16'h0000, 1'b1);
   endtask

   task automatic test_backpressure();
      program_timing(make_timing(1, 1, 1, 1, 1, 1, 1));
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      // hold responses off while requests keep coming, so the input stalls
      hold_receiver();
      run_command(owbm_pkg::OP_TEMP, 8'h00, 16'hFC90, 1'b1);
      wait_for_responses();
      run_command(owbm_pkg::OP_READ, 8'h00, 16'h00C3, 1'b1);
   endtask

   task automatic random_phase(input int send_pct, input int recv_pct, input int quota);
      int first;
      program_timing(make_timing($urandom_range(0, 3), $urandom_range(0, 3),
                                 $urandom_range(0, 3), $urandom_range(0, 2),
                                 $urandom_range(0, 2), $urandom_range(0, 2),
                                 $urandom_range(0, 2)));
      sender_idle_pct    = send_pct;
      receiver_stall_pct = recv_pct;
      first              = requests_sent;
      while (requests_sent - first < quota) begin
         if ($urandom_range(0, 99) < 15)
            send_request(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom));
         else
            run_command(3'($urandom_range(owbm_pkg::OP_RESET, owbm_pkg::OP_TEMP)),
                        8'($urandom), 16'($urandom), 1'($urandom));
      end
   endtask

   task automatic test_random_traffic();
      random_phase(0, 0, 25);
      random_phase(46, 0, 25);
      random_phase(0, 46, 25);
      random_phase(35, 35, 25);
   endtask

   initial begin
      clear_prediction();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_timing();
      test_opcodes_and_corners();
      test_zero_timing();
      test_retime_mid_command();
      test_max_timing();
      test_backpressure();
      test_random_traffic();
      wait_for_responses();
      repeat (16) @(posedge clock);
      if (mismatch_count == 0 && expected_status.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/owbm_pkg.sv
src/owbm_front.sv
src/owbm_queue.sv
src/owbm_back.sv
src/one_wire_bus_master.sv
tb/testbench.sv
